// File: src/bounding_box_and_sphere_core_macros.svh
// Assertion macros for the bounding box and sphere core.
`ifndef BOUNDING_BOX_AND_SPHERE_CORE_MACROS_SVH
`define BOUNDING_BOX_AND_SPHERE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bbs_pkg.sv
// Shared widths and types for the bounding box and sphere core.
`timescale 1ns / 1ps

package bbs_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
  localparam int CNT_WIDTH   = $clog2(COORD_WIDTH + 1);
  localparam int NUM_AXES    = 3;
  localparam int IN_DATA_W   = ((NUM_AXES * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((10 * COORD_WIDTH + 7) / 8) * 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // tracker control: a vertex transfer and its last flag
  typedef struct packed {
    logic load;
    logic last;
  } trk_ctrl_t;

endpackage

// File: src/bbs_tracker.sv
// Per-axis running minimum and maximum with batch seeding.
`timescale 1ns / 1ps

module bbs_tracker
  import bbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  trk_ctrl_t            ctrl,
  input  coord_t [NUM_AXES-1:0] vert,
  output coord_t [NUM_AXES-1:0] vmin,
  output coord_t [NUM_AXES-1:0] vmax
);

  logic started;

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      vmin    <= '0;
      vmax    <= '0;
    end else if (ctrl.load) begin
      started <= !ctrl.last;
      for (int a = 0; a < NUM_AXES; a++) begin
        if (!started || (vert[a] < vmin[a])) begin
          vmin[a] <= vert[a];
        end
        if (!started || (vert[a] > vmax[a])) begin
          vmax[a] <= vert[a];
        end
      end
    end
  end

endmodule

// File: src/bbs_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps

module bbs_isqrt
  import bbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SQ_WIDTH-1:0]    radicand,
  output logic                   done,
  output logic [COORD_WIDTH-1:0] root
);

  logic [SQ_WIDTH-1:0]    rad;
  logic [COORD_WIDTH+1:0] rem;
  logic [CNT_WIDTH-1:0]   cnt;
  logic                   busy;

  logic [COORD_WIDTH+1:0] rem_sh;
  logic [COORD_WIDTH+1:0] trial;
  logic                   fits;

  always_comb begin
    rem_sh = {rem[COORD_WIDTH-1:0], rad[SQ_WIDTH-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(COORD_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_WIDTH'(1);
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: restoring digit recurrence
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[SQ_WIDTH-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[COORD_WIDTH-2:0], fits};
    end
  end

endmodule

// File: src/bounding_box_and_sphere_core.sv
// Top level: vertex stream in, bounding box, centre and sphere radius out.
//
//   channel | dir | handshake        | payload
//   s_*     | in  | s_tvalid/tready  | s_tdata: vert_x, vert_y, vert_z; s_tlast: final_vertex
//   m_*     | out | m_tvalid/tready  | m_tdata: box min/max, centre, sphere_radius
//
// A vertex without tlast is taken while s_tready is high; a vertex with tlast
// drops s_tready until the result has been handed to the output register:
// three diff/square/accumulate passes through one multiplier, then the
// bit-serial square root at one bit per cycle and a wait for its done flag.
// rst is synchronous, active high; it clears the bounds and arms seeding.
// The result sits in an output register, so vertices of the next batch are
// taken while it waits; only a second result stalls until m_tready.
`timescale 1ns / 1ps
`include "bounding_box_and_sphere_core_macros.svh"

module bounding_box_and_sphere_core
  import bbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // vert_x, vert_y, vert_z (low to high)
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // centre_x, centre_y, centre_z, sphere_radius (low to high)
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIFF    = 3'd1;
  localparam logic [2:0] S_SQR     = 3'd2;
  localparam logic [2:0] S_ACC     = 3'd3;
  localparam logic [2:0] S_ROOT_GO = 3'd4;
  localparam logic [2:0] S_ROOT    = 3'd5;
  localparam logic [2:0] S_LOAD    = 3'd6;

  logic [2:0]             state;
  logic [1:0]             axis;
  logic [COORD_WIDTH-1:0] d_reg;
  logic [SQ_WIDTH-1:0]    prod;
  logic [SQ_WIDTH-1:0]    sum;
  coord_t [NUM_AXES-1:0]  centre;

  coord_t [NUM_AXES-1:0]  vert;
  coord_t [NUM_AXES-1:0]  vmin;
  coord_t [NUM_AXES-1:0]  vmax;
  trk_ctrl_t              trk_ctrl;

  logic                   in_xfer;
  logic [COORD_WIDTH-1:0] extent;
  logic [COORD_WIDTH-1:0] half;
  logic [SQ_WIDTH-1:0]    sq;
  logic                   sq_start;
  logic                   sq_done;
  logic [COORD_WIDTH-1:0] radius;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      vert[a] = s_tdata[a*COORD_WIDTH +: COORD_WIDTH];
    end
    trk_ctrl.load = in_xfer;
    trk_ctrl.last = s_tlast;
  end

  bbs_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .ctrl (trk_ctrl),
    .vert (vert),
    .vmin (vmin),
    .vmax (vmax)
  );

  // max >= min, so the extent fits unsigned in COORD_WIDTH bits
  always_comb begin
    extent = COORD_WIDTH'(vmax[axis] - vmin[axis]);
    half   = extent >> 1;
  end

  assign sq       = d_reg * d_reg;
  assign sq_start = (state == S_ROOT_GO);

  bbs_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sum),
    .done     (sq_done),
    .root     (radius)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer && s_tlast) begin
            axis  <= '0;
            state <= S_DIFF;
          end
        end
        S_DIFF:    state <= S_SQR;
        S_SQR:     state <= S_ACC;
        S_ACC: begin
          if (axis == 2'(NUM_AXES - 1)) begin
            state <= S_ROOT_GO;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_DIFF;
          end
        end
        S_ROOT_GO: state <= S_ROOT;
        S_ROOT: begin
          if (sq_done) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

  // datapath around the shared multiplier
  always_ff @(posedge clk) begin
    if (in_xfer && s_tlast) begin
      sum <= '0;
    end
    if (state == S_DIFF) begin
      d_reg        <= extent - half;
      centre[axis] <= coord_t'(vmin[axis] + half);
    end
    if (state == S_SQR) begin
      prod <= sq;
    end
    if (state == S_ACC) begin
      sum <= sum + prod;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_LOAD) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_LOAD) && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_DATA_W'({radius, centre[2], centre[1], centre[0],
                              vmax[2], vmax[1], vmax[0],
                              vmin[2], vmin[1], vmin[0]});
    end
  end

  `BBS_ASSERT_NEXT(a_busy_after_last, in_xfer && s_tlast, !s_tready, "ready after last vertex")
  `BBS_ASSERT_IMP(a_done_in_root, sq_done, state == S_ROOT, "root done outside root wait")
  `BBS_ASSERT_IMP(a_root_floor, sq_done, (SQ_WIDTH'(radius) * SQ_WIDTH'(radius)) <= sum, "root too large")

endmodule
